// ----- design/tcw_pkg.sv -----
// Shared constants, payload types and control structs of the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_W   = 5;
  localparam int COL_W   = 7;
  localparam int CELL_W  = 16;

  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_LAST = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

  // Request kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Character and attribute codes
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] RESET_ATTR   = 8'h07;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_code;
    logic [ROW_W-1:0] read_row;
    logic [COL_W-1:0] read_col;
  } tcw_in_t;

  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_attr;
    logic [ROW_W-1:0] cur_row;
    logic [COL_W-1:0] cur_col;
  } tcw_out_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;        // capture the accepted request
    logic exec_put;     // apply a put that needs no scroll
    logic scroll_start; // home the column, restart the sweep counter
    logic fill_start;   // home the cursor, restart the sweep counter
    logic sweep_copy;   // move one cell up by a row
    logic sweep_blank;  // blank one cell
    logic rd_issue;     // read the requested cell
    logic load_out;     // load the result register
    logic out_cell;     // result takes the read cell, else zeros
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic kind_put;
    logic kind_clear;
    logic kind_read;
    logic is_ordinary;
    logic need_scroll;
    logic rd_ok;
    logic copy_end;
    logic sweep_end;
  } tcw_sts_t;

endpackage

// ----- design/tcw_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/tcw_ctrl.sv -----
// Control state machine of the text console writer.
module tcw_ctrl import tcw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  tcw_sts_t sts,
  output tcw_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_SCROLL = 7'b0001000,
    ST_BLANK  = 7'b0010000,
    ST_FILL   = 7'b0100000,
    ST_RDWAIT = 7'b1000000
  } tcw_state_t;

  tcw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        cmd.sweep_blank = 1'b1;
        if (sts.sweep_end) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !out_valid_r || out_ready;
        if (in_valid && in_ready) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        priority if (sts.kind_put) begin
          if (sts.need_scroll) begin
            cmd.scroll_start = 1'b1;
            state_nxt        = ST_SCROLL;
          end else begin
            cmd.exec_put = 1'b1;
            cmd.load_out = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (sts.kind_clear) begin
          cmd.fill_start = 1'b1;
          state_nxt      = ST_FILL;
        end else if (sts.kind_read && sts.rd_ok) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = ST_RDWAIT;
        end else begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        cmd.sweep_copy = 1'b1;
        if (sts.copy_end) begin
          state_nxt = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cmd.sweep_blank = 1'b1;
        if (sts.sweep_end) begin
          if (sts.is_ordinary) begin
            state_nxt = ST_EXEC;
          end else begin
            cmd.load_out = 1'b1;
            state_nxt    = ST_IDLE;
          end
        end
      end
      ST_FILL: begin
        cmd.sweep_blank = 1'b1;
        if (sts.sweep_end) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_RDWAIT: begin
        cmd.load_out = 1'b1;
        cmd.out_cell = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- design/tcw_dp.sv -----
// Datapath of the text console writer: cursor, sweep counter, write staging, result.
module tcw_dp import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_in_t           in_data,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  tcw_cmd_t          cmd,
  output tcw_sts_t          sts,
  output tcw_out_t          out_data,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [CELL_W-1:0] ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [CELL_W-1:0] ram_rdata
);

  tcw_in_t           req_r, req_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [7:0]        attr_r, attr_nxt;
  logic [7:0]        fill_attr_r, fill_attr_nxt;
  logic [ADDR_W-1:0] sw_r, sw_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_copy_r, pend_copy_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [CELL_W-1:0] pend_data_r, pend_data_nxt;
  tcw_out_t          out_r, out_nxt;

  logic              is_nl, is_bs, is_ord, full, last_row, sweeping;
  logic              put_we;
  logic [ROW_W-1:0]  put_row;
  logic [COL_W-1:0]  put_col;
  logic [7:0]        put_chr;
  logic [ADDR_W-1:0] put_addr, req_addr;

  always_comb begin
    is_nl    = req_r.char_code == CH_NEWLINE;
    is_bs    = req_r.char_code == CH_BACKSPACE;
    is_ord   = !is_nl && !is_bs;
    full     = col_r >= COL_W'(COLUMNS);
    last_row = row_r == ROW_W'(ROWS - 1);

    sts.kind_put    = req_r.kind == KIND_PUT;
    sts.kind_clear  = req_r.kind == KIND_CLEAR;
    sts.kind_read   = req_r.kind == KIND_READ;
    sts.is_ordinary = is_ord;
    sts.need_scroll = last_row && (is_nl || (is_ord && full));
    sts.rd_ok       = (req_r.read_row < ROW_W'(ROWS)) && (req_r.read_col < COL_W'(COLUMNS));
    sts.copy_end    = sw_r == COPY_LAST;
    sts.sweep_end   = sw_r == CELL_LAST;
  end

  // Cursor update and the single-cell write of a put
  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    put_we  = 1'b0;
    put_row = row_r;
    put_col = col_r;
    put_chr = req_r.char_code;
    if (cmd.exec_put) begin
      priority if (is_nl) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else if (is_bs) begin
        if (col_r == '0 && row_r == '0) begin
          // top-left corner: nothing to do
        end else if (col_r == '0) begin
          row_nxt = row_r - 1'b1;
          col_nxt = COL_W'(COLUMNS - 1);
          put_we  = 1'b1;
          put_row = row_nxt;
          put_col = col_nxt;
          put_chr = CH_SPACE;
        end else begin
          col_nxt = col_r - 1'b1;
          put_we  = 1'b1;
          put_col = col_nxt;
          put_chr = CH_SPACE;
        end
      end else if (full) begin
        row_nxt = row_r + 1'b1;
        col_nxt = COL_W'(1);
        put_we  = 1'b1;
        put_row = row_nxt;
        put_col = '0;
      end else begin
        col_nxt = col_r + 1'b1;
        put_we  = 1'b1;
      end
    end
    if (cmd.scroll_start) begin
      col_nxt = '0;
    end
    if (cmd.fill_start) begin
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  assign put_addr = ADDR_W'(put_row) * COLS_A + ADDR_W'(put_col);
  assign req_addr = ADDR_W'(req_r.read_row) * COLS_A + ADDR_W'(req_r.read_col);
  assign sweeping = cmd.sweep_copy || cmd.sweep_blank;

  always_comb begin
    req_nxt       = cmd.latch ? in_data : req_r;
    attr_nxt      = cfg_valid ? cfg_data : attr_r;
    fill_attr_nxt = (cmd.scroll_start || cmd.fill_start) ? attr_r : fill_attr_r;

    sw_nxt = sw_r;
    if (cmd.scroll_start || cmd.fill_start) begin
      sw_nxt = '0;
    end else if (sweeping) begin
      sw_nxt = sw_r + 1'b1;
    end

    // Stage every write in a register so copies can wait for the read data
    pend_nxt      = sweeping || put_we;
    pend_copy_nxt = cmd.sweep_copy;
    pend_addr_nxt = sweeping ? sw_r : put_addr;
    pend_data_nxt = put_we ? {attr_r, put_chr} : {fill_attr_r, CH_SPACE};

    out_nxt = out_r;
    if (cmd.load_out) begin
      out_nxt.cell_char = cmd.out_cell ? ram_rdata[7:0] : 8'h00;
      out_nxt.cell_attr = cmd.out_cell ? ram_rdata[15:8] : 8'h00;
      out_nxt.cur_row   = row_nxt;
      out_nxt.cur_col   = col_nxt;
    end
  end

  assign ram_raddr = cmd.rd_issue ? req_addr : sw_r + COLS_A;
  assign ram_we    = pend_r;
  assign ram_waddr = pend_addr_r;
  assign ram_wdata = pend_copy_r ? ram_rdata : pend_data_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      attr_r      <= RESET_ATTR;
      fill_attr_r <= RESET_ATTR;
      sw_r        <= '0;
      pend_r      <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      attr_r      <= attr_nxt;
      fill_attr_r <= fill_attr_nxt;
      sw_r        <= sw_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    pend_copy_r <= pend_copy_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
    out_r       <= out_nxt;
  end

endmodule

// ----- design/text_console_writer.sv -----
// Top level of the text console writer: controller, datapath and screen RAM.
//
// A character-cell console of COLUMNS x ROWS cells (attribute in the high byte,
// character in the low byte) with a cursor. Each request on the in_ channel is
// a put, a clear or a read; each gives exactly one result on the out_ channel
// with the cursor position after the request and, for reads, the cell.
// The cfg_ channel writes the attribute byte; it is always ready and is
// meant to be written while no request is in flight.
//
// A read inside the screen makes one RAM read with registered data. A scroll
// (newline or wrap on the last row) walks the whole store, and when the
// request is a character, the character is then written; a clear also walks
// the whole store. Scroll and clear walk the store one cell per cycle through
// the single write port of the RAM. The block takes no new request until
// it is back in idle after the last one. After reset the block blanks all
// cells (space, attribute 7), one per cycle, and takes no request until
// that pass is done. While the receiver stalls the result register holds,
// and the next request is taken in the cycle the held result leaves.
module text_console_writer import tcw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tcw_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output tcw_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  tcw_cmd_t          cmd;
  tcw_sts_t          sts;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Take attribute writes in any cycle
  assign cfg_ready = 1'b1;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Screen store: one cell per entry, row-major
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- test/tb_top.sv -----
// Testbench for the text console writer: screen mirror, request driver and result check.
`timescale 1ns / 1ps

module tb_top import tcw_pkg::*; ();

  // Shadow copy of the screen, cursor and attribute; predicts each result.
  class screen_mirror;
    logic [CELL_W-1:0] cells [CELLS];
    int                row;
    int                col;
    logic [7:0]        attr;
    tcw_out_t          pending_q [$];
    int                mismatches;
    int                results_seen;
    int                reads;
    int                clears;
    int                scrolls;

    function new();
      attr = RESET_ATTR;
      blank_all();
    endfunction

    function void set_attr(logic [7:0] value);
      attr = value;
    endfunction

    function void blank_all();
      foreach (cells[i]) cells[i] = {attr, CH_SPACE};
      row = 0;
      col = 0;
    endfunction

    // Move to column 0 of the next row; scroll when already on the last row.
    function void line_feed();
      col = 0;
      if (row == ROWS - 1) begin
        for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = {attr, CH_SPACE};
        scrolls++;
      end else begin
        row++;
      end
    endfunction

    function void note_request(tcw_in_t req);
      tcw_out_t res;
      res = '0;
      unique case (req.kind)
        KIND_PUT: begin
          if (req.char_code == CH_NEWLINE) begin
            line_feed();
          end else if (req.char_code == CH_BACKSPACE) begin
            // Top-left corner leaves everything alone.
            if (row != 0 || col != 0) begin
              if (col == 0) begin
                row--;
                col = COLUMNS;
              end
              col--;
              cells[row * COLUMNS + col] = {attr, CH_SPACE};
            end
          end else begin
            if (col >= COLUMNS) line_feed();
            cells[row * COLUMNS + col] = {attr, req.char_code};
            col++;
          end
        end
        KIND_CLEAR: begin
          blank_all();
          clears++;
        end
        KIND_READ: begin
          reads++;
          if (req.read_row < ROWS && req.read_col < COLUMNS)
            {res.cell_attr, res.cell_char} = cells[req.read_row * COLUMNS + req.read_col];
        end
        default: ;
      endcase
      res.cur_row = row[ROW_W-1:0];
      res.cur_col = col[COL_W-1:0];
      pending_q.push_back(res);
    endfunction

    function void check_result(tcw_out_t got);
      tcw_out_t want;
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result: char %02h attr %02h row %0d col %0d", $realtime,
                   got.cell_char, got.cell_attr, got.cur_row, got.cur_col);
        return;
      end
      want = pending_q.pop_front();
      if (got.cell_char !== want.cell_char || got.cell_attr !== want.cell_attr ||
          got.cur_row !== want.cur_row || got.cur_col !== want.cur_col) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] mismatch: want char %02h attr %02h row %0d col %0d, %s",
                   $realtime, want.cell_char, want.cell_attr, want.cur_row, want.cur_col,
                   $sformatf("got char %02h attr %02h row %0d col %0d",
                             got.cell_char, got.cell_attr, got.cur_row, got.cur_col));
      end
    endfunction
  endclass

  // kind 3 is not a valid request; the block answers it without any change
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // no-handshake cycles allowed: reset clear, a full scroll and the long
  // receiver hold each fit several times over
  localparam int STALL_LIMIT = 10000;
  localparam int LONG_HOLD   = 400;
  localparam int TAIL_CYCLES = 20;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  tcw_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  tcw_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  logic       quiet;     // last phase: no idling on either side
  logic       hold_ask;  // ask the receiver for one long hold-off
  int         items;
  int         attr_settings;
  int         stuck_cycles = 0;

  screen_mirror mirror = new();

  text_console_writer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Check every result taken by the receiver against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) mirror.check_result(out_data);
  end

  // Watchdog: count cycles in which no channel completes a handshake.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $realtime, stuck_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random stall bursts and ready stretches, one long hold on
  // request, always ready once the quiet phase starts.
  initial begin
    int stall_left;
    int run_left;
    int hold_left;
    bit hold_used;
    stall_left = 0;
    run_left   = 0;
    hold_left  = 0;
    hold_used  = 1'b0;
    out_ready  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_ask && !hold_used) begin
        hold_left = LONG_HOLD;
        hold_used = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        out_ready <= 1'b1;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ready <= 1'b0;
      end else begin
        run_left = $urandom_range(1, 60) - 1;
        out_ready <= 1'b1;
      end
    end
  end

  function automatic tcw_in_t make_req(logic [1:0] k, logic [7:0] c,
                                       logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
    tcw_in_t r;
    r.kind      = k;
    r.char_code = c;
    r.read_row  = rr;
    r.read_col  = rc;
    return r;
  endfunction

  // Any byte but newline and backspace.
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_NEWLINE || c == CH_BACKSPACE);
    return c;
  endfunction

  // Drop valid for a burst of idle cycles; called and returns at a falling edge.
  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Offer one request, hold it until taken, then note it in the mirror.
  // Valid stays high on return; the next call or a pause decides its fate.
  task automatic send_request(tcw_in_t req);
    if (!quiet && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 18));
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk);
    while (!in_ready);
    mirror.note_request(req);
    items++;
    @(negedge clk);
  endtask

  task automatic put_char(logic [7:0] c);
    send_request(make_req(KIND_PUT, c, ROW_W'($urandom_range(0, 31)),
                          COL_W'($urandom_range(0, 127))));
  endtask

  task automatic read_cell(logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
    send_request(make_req(KIND_READ, 8'($urandom_range(0, 255)), rr, rc));
  endtask

  task automatic clear_screen();
    send_request(make_req(KIND_CLEAR, 8'($urandom_range(0, 255)),
                          ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127))));
  endtask

  // Stop offering and hold until every predicted result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk);
    while (mirror.pending_q.size() != 0);
  endtask

  // Write the attribute register; only called with nothing in flight.
  task automatic write_attr(logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    mirror.set_attr(value);
    attr_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Corners first: reset contents, reads at and past the edges, backspace at
  // the home position, the unused kind, wrap of backspace to the row above,
  // scroll by newline and by a wrap on the last row, and a clear.
  task automatic directed_checks();
    read_cell(ROW_W'(0), COL_W'(0));
    read_cell(ROW_W'(ROWS - 1), COL_W'(COLUMNS - 1));
    read_cell(ROW_W'(ROWS), COL_W'(0));
    read_cell(ROW_W'(0), COL_W'(COLUMNS));
    read_cell(ROW_W'(31), COL_W'(127));
    put_char(CH_BACKSPACE);
    send_request(make_req(KIND_UNUSED, 8'hFF, 5'h1F, 7'h7F));
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h41);
    put_char(CH_BACKSPACE);
    read_cell(ROW_W'(0), COL_W'(1));
    read_cell(ROW_W'(0), COL_W'(2));
    put_char(CH_NEWLINE);
    put_char(8'h09);
    put_char(CH_BACKSPACE);
    put_char(CH_BACKSPACE);
    read_cell(ROW_W'(0), COL_W'(COLUMNS - 1));
    // walk past the last row, fill it, step back on the full row, then wrap
    repeat (ROWS) put_char(CH_NEWLINE);
    repeat (COLUMNS) put_char(plain_char());
    put_char(CH_BACKSPACE);
    put_char(plain_char());
    put_char(plain_char());
    read_cell(ROW_W'(ROWS - 2), COL_W'(COLUMNS - 1));
    read_cell(ROW_W'(ROWS - 1), COL_W'(0));
    clear_screen();
    read_cell(ROW_W'(0), COL_W'(0));
  endtask

  // Random traffic shaped as text runs, row fills that end in a wrap or a
  // backspace, newline and backspace bursts, reads, rare clears and noise.
  task automatic run_traffic(int target);
    int pick;
    int n;
    while (items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        n = $urandom_range(1, 40);
        repeat (n) put_char(plain_char());
      end else if (pick < 50) begin
        // fill the row exactly, then wrap or step back on the full row
        n = (mirror.col < COLUMNS) ? COLUMNS - mirror.col : 0;
        repeat (n) put_char(plain_char());
        if ($urandom_range(0, 1) == 0) put_char(CH_BACKSPACE);
        else put_char(plain_char());
      end else if (pick < 62) begin
        n = $urandom_range(1, 3);
        repeat (n) put_char(CH_NEWLINE);
      end else if (pick < 72) begin
        n = $urandom_range(1, 6);
        repeat (n) put_char(CH_BACKSPACE);
      end else if (pick < 90) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0)
            read_cell(ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
          else
            read_cell(ROW_W'($urandom_range(0, ROWS - 1)),
                      COL_W'($urandom_range(0, COLUMNS - 1)));
        end
      end else if (pick < 93) begin
        clear_screen();
      end else if (pick < 96) begin
        send_request(make_req(KIND_UNUSED, 8'($urandom_range(0, 255)),
                              ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127))));
      end else begin
        n = $urandom_range(1, 5);
        repeat (n)
          send_request(make_req(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)),
                                ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127))));
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    quiet         = 1'b0;
    hold_ask      = 1'b0;
    items         = 0;
    attr_settings = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // wait out the clearing pass that follows reset
    do @(posedge clk);
    while (!in_ready);
    @(negedge clk);

    directed_checks();

    drain();
    write_attr(8'h00);
    run_traffic(230);

    // long receiver hold while the sender keeps pushing
    drain();
    write_attr(8'hFF);
    hold_ask <= 1'b1;
    run_traffic(360);

    drain();
    write_attr(8'($urandom_range(1, 254)));
    run_traffic(480);

    drain();
    write_attr(8'($urandom_range(0, 255)));
    run_traffic(590);

    // final stretch at full rate on both sides
    drain();
    quiet <= 1'b1;
    write_attr(8'($urandom_range(0, 255)));
    run_traffic(690);

    in_valid <= 1'b0;
    do @(posedge clk);
    while (mirror.pending_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d results under %0d attribute writes:",
             items, mirror.results_seen, attr_settings);
    $display("  %0d reads, %0d clears, %0d scrolls, %0d mismatches",
             mirror.reads, mirror.clears, mirror.scrolls, mirror.mismatches);
    if (mirror.mismatches == 0 && mirror.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_ctrl.sv
design/tcw_dp.sv
design/text_console_writer.sv
test/tb_top.sv
